[hdl/fnlg_pkg.sv]
`timescale 1ns / 1ps

package fnlg_pkg;

    // Field and register widths.
    localparam int SAMPLE_W  = 16;
    localparam int SEED_W    = 32;
    localparam int ALPHA_W   = 16;
    localparam int LOOPLEN_W = 21;
    localparam int INDEX_W   = 20;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Cross-fade length and the address width of the head store.
    localparam int XFADE_SAMPLES = 2048;
    localparam int FADE_W        = $clog2(XFADE_SAMPLES);

    // Loop length limits applied before use.
    localparam logic [LOOPLEN_W-1:0] MIN_LOOP = LOOPLEN_W'(2 * XFADE_SAMPLES);
    localparam logic [LOOPLEN_W-1:0] MAX_LOOP = LOOPLEN_W'(1048576);

    // Register reset values.
    localparam logic [SEED_W-1:0]    SEED_RST    = 32'hDEAD_BEEF;
    localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 16'd7449;
    localparam logic [LOOPLEN_W-1:0] LOOPLEN_RST = 21'd176400;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPLEN = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        a = s ^ (s << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // Low 16 bits minus 32768, then one step toward zero.
    function automatic t_sample noise_to_x(input logic [SAMPLE_W-1:0] low);
        t_sample v;
        t_sample x;
        v = {~low[SAMPLE_W-1], low[SAMPLE_W-2:0]};
        if (v > 0) begin
            x = v - 16'sd1;
        end else if (v < 0) begin
            x = v + 16'sd1;
        end else begin
            x = '0;
        end
        return x;
    endfunction

endpackage

[hdl/fnlg_restart_if.sv]
`timescale 1ns / 1ps

// Input channel: one item per sample request.
interface fnlg_restart_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

[hdl/fnlg_sample_if.sv]
`timescale 1ns / 1ps

// Output channel: one audio sample per item.
interface fnlg_sample_if;
    logic               valid;
    logic               ready;
    fnlg_pkg::t_sample  sample;
    logic               loop_end;

    modport source (output valid, output sample, output loop_end, input ready);
    modport sink (input valid, input sample, input loop_end, output ready);
endinterface

[hdl/filtered_noise_loop_generator_top.sv]
`timescale 1ns / 1ps

// Looping low-passed noise generator. Each input item asks for one 16-bit
// audio sample; a restart bit in the item reseeds the xorshift32 generator,
// clears the filter and returns to the start of the loop before that sample.
// The noise passes a one-pole low-pass filter (alpha as a 0.16 fraction) and
// the last 2048 samples of each loop are cross-faded linearly toward the
// first 2048, which are kept in an internal store, so the loop repeats
// without a click. loop_end marks the last sample of a loop. A sequencer runs
// the filter and the cross-fade through a single shared 18 x 18 multiplier
// and holds its last state until the output register is free; a new item is
// taken as soon as the sequencer is back in its idle state, while the
// previous result may still be waiting in the output register.
// Configuration (seed, alpha, loop length) is to be written only while idle;
// the user is bound to this, as the block itself does not enforce it.
module filtered_noise_loop_generator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fnlg_restart_if.sink                    i_in,
    fnlg_sample_if.source                   o_out,
    input  logic                            i_cfg_we,
    input  logic [fnlg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fnlg_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LO   = 3'd1;
    localparam logic [2:0] S_HI   = 3'd2;
    localparam logic [2:0] S_X    = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_Y    = 3'd5;
    localparam logic [2:0] S_MIX  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam int PW = 49;             // width of the wide filter product
    localparam int MW = 28;             // width of the cross-fade sum

    // Configuration registers.
    logic [fnlg_pkg::SEED_W-1:0]    r_seed;
    logic [fnlg_pkg::ALPHA_W-1:0]   r_alpha;
    logic [fnlg_pkg::LOOPLEN_W-1:0] r_loop_len;

    // Loop state and working registers.
    logic [2:0]                     r_state;
    logic [fnlg_pkg::SEED_W-1:0]    r_noise;
    logic signed [fnlg_pkg::ACC_W-1:0] r_acc;
    logic [fnlg_pkg::INDEX_W-1:0]   r_idx;
    logic [fnlg_pkg::INDEX_W-1:0]   r_pos;
    fnlg_pkg::t_sample              r_x;
    fnlg_pkg::t_sample              r_y;
    fnlg_pkg::t_sample              r_head;
    logic                           r_fade;
    logic [fnlg_pkg::FADE_W-1:0]    r_j;
    logic signed [35:0]             r_prod;
    logic [32:0]                    r_plo;
    logic signed [PW-1:0]           r_p;

    // Output register.
    logic                           r_out_valid;
    fnlg_pkg::t_sample              r_out_sample;
    logic                           r_out_loop_end;

    // Head store: first samples of the current loop.
    logic [fnlg_pkg::SAMPLE_W-1:0]  r_head_mem [fnlg_pkg::XFADE_SAMPLES];

    logic                           w_accept;
    logic [fnlg_pkg::LOOPLEN_W-1:0] w_len;
    logic [fnlg_pkg::INDEX_W-1:0]   w_lenm1;
    logic [fnlg_pkg::LOOPLEN_W-1:0] w_fade_start;
    logic [fnlg_pkg::SEED_W-1:0]    w_noise_base;
    logic [fnlg_pkg::SEED_W-1:0]    n_noise;
    logic [fnlg_pkg::INDEX_W-1:0]   w_idx_base;
    logic [fnlg_pkg::LOOPLEN_W-1:0] w_pos_diff;
    logic signed [17:0]             w_coef;
    logic signed [17:0]             w_mul_a;
    logic signed [17:0]             w_mul_b;
    logic signed [16:0]             w_diff;
    logic                           w_head_wr;
    logic signed [32:0]             w_t;
    logic signed [fnlg_pkg::ACC_W-1:0] n_acc;
    fnlg_pkg::t_sample              n_y;
    logic signed [MW-1:0]           w_mix;
    fnlg_pkg::t_sample              w_faded;
    fnlg_pkg::t_sample              w_result;
    logic                           w_loop_end;
    logic                           w_load;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= fnlg_pkg::SEED_RST;
            r_alpha    <= fnlg_pkg::ALPHA_RST;
            r_loop_len <= fnlg_pkg::LOOPLEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fnlg_pkg::CFG_SEED:    r_seed     <= i_cfg_data;
                fnlg_pkg::CFG_ALPHA:   r_alpha    <= i_cfg_data[fnlg_pkg::ALPHA_W-1:0];
                fnlg_pkg::CFG_LOOPLEN: r_loop_len <= i_cfg_data[fnlg_pkg::LOOPLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective loop length, clamped to its legal range.
    always_comb begin
        if (r_loop_len < fnlg_pkg::MIN_LOOP) begin
            w_len = fnlg_pkg::MIN_LOOP;
        end else if (r_loop_len > fnlg_pkg::MAX_LOOP) begin
            w_len = fnlg_pkg::MAX_LOOP;
        end else begin
            w_len = r_loop_len;
        end
    end

    assign w_lenm1      = fnlg_pkg::INDEX_W'(w_len - 1'b1);
    assign w_fade_start = w_len - fnlg_pkg::LOOPLEN_W'(fnlg_pkg::XFADE_SAMPLES);

    // Start of an item: restart selects the seed and a cleared index.
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_noise_base = i_in.restart ? r_seed : r_noise;
    assign n_noise      = fnlg_pkg::xorshift32(w_noise_base);
    assign w_idx_base   = i_in.restart ? '0 : r_idx;
    assign w_pos_diff   = {1'b0, r_pos} - w_fade_start;

    // Shared multiplier operand selection.
    assign w_coef = 18'sh10000 - $signed({2'b00, r_alpha});
    assign w_diff = {r_head[15], r_head} - {r_y[15], r_y};

    always_comb begin
        unique case (r_state)
            S_LO: begin
                w_mul_a = w_coef;
                w_mul_b = $signed({2'b00, r_acc[15:0]});
            end
            S_HI: begin
                w_mul_a = w_coef;
                w_mul_b = {{2{r_acc[31]}}, r_acc[31:16]};
            end
            S_X: begin
                w_mul_a = $signed({2'b00, r_alpha});
                w_mul_b = {{2{r_x[15]}}, r_x};
            end
            S_MIX: begin
                w_mul_a = {w_diff[16], w_diff};
                w_mul_b = $signed({{(18 - fnlg_pkg::FADE_W){1'b0}}, r_j});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Filter update: alpha * x plus the decayed accumulator, cut toward zero.
    assign w_t   = r_p[PW-1:16] + 33'(r_p[PW-1] && (r_p[15:0] != '0));
    assign n_acc = r_prod[31:0] + w_t[31:0];
    assign n_y   = r_acc[31:16] + 16'(r_acc[31] && (r_acc[15:0] != '0));

    // Cross-fade: y * 2048 + (head - y) * j, divided toward zero.
    assign w_mix    = ($signed({{(MW - 16){r_y[15]}}, r_y}) <<< fnlg_pkg::FADE_W)
                    + r_prod[MW-1:0];
    assign w_faded  = w_mix[fnlg_pkg::FADE_W +: 16]
                    + 16'(w_mix[MW-1] && (w_mix[fnlg_pkg::FADE_W-1:0] != '0));
    assign w_result = r_fade ? w_faded : r_y;

    assign w_head_wr  = (r_pos < fnlg_pkg::INDEX_W'(fnlg_pkg::XFADE_SAMPLES));
    assign w_loop_end = (r_pos == w_lenm1);
    assign w_load     = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_noise <= fnlg_pkg::SEED_RST;
            r_acc   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_noise <= n_noise;
                        r_x     <= fnlg_pkg::noise_to_x(n_noise[15:0]);
                        r_pos   <= (w_idx_base > w_lenm1) ? w_lenm1 : w_idx_base;
                        if (i_in.restart) begin
                            r_acc <= '0;
                        end
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_fade  <= ({1'b0, r_pos} >= w_fade_start);
                    r_j     <= w_pos_diff[fnlg_pkg::FADE_W-1:0];
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_plo   <= r_prod[32:0];
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_X;
                end
                S_X: begin
                    r_p     <= $signed({r_prod[32:0], 16'h0000}) + $signed({16'h0000, r_plo});
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= n_acc;
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_y     <= n_y;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_load) begin
                        if (w_loop_end) begin
                            r_noise <= r_seed;
                            r_acc   <= '0;
                            r_idx   <= '0;
                        end else begin
                            r_idx   <= r_pos + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Head store: read the fade partner, record the first samples of a loop.
    always_ff @(posedge i_clk) begin
        if (r_state == S_HI) begin
            r_head <= r_head_mem[r_j];
        end
        if ((r_state == S_MIX) && w_head_wr) begin
            r_head_mem[r_pos[fnlg_pkg::FADE_W-1:0]] <= r_y;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_sample   <= w_result;
            r_out_loop_end <= w_loop_end;
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.sample   = r_out_sample;
    assign o_out.loop_end = r_out_loop_end;

    // An accepted item always starts the multiply sequence.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LO))
        else $error("accepted item did not start the sequence");

    // The end of a loop leaves the generator reseeded and the filter clear.
    a_loop_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_loop_end) |=> (r_idx == '0) && (r_acc == '0)
            && (r_noise == $past(r_seed)))
        else $error("loop end did not restart the loop state");

    // While an item is in progress, the working position never lies beyond the loop.
    a_pos_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pos <= w_lenm1))
        else $error("position beyond loop length");

    // A sample is never both recorded in the head store and cross-faded.
    a_head_or_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> !(r_fade && w_head_wr))
        else $error("head write and cross-fade overlap");

endmodule

[sim/tb_filtered_noise_loop_generator_top.sv]
`timescale 1ns / 1ps

module tb_filtered_noise_loop_generator_top;

    // Spare register index, which the block ignores.
    localparam logic [fnlg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;

    // Restart bits of the opening directed items, taken from bit 0 upwards.
    localparam logic [13:0] DIRECTED_RESTARTS = 14'b00010000011000;

    typedef struct packed {
        fnlg_pkg::t_sample sample;
        logic              loop_end;
    } t_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_EVERY_THIRD,
        RX_MOSTLY
    } t_rx_mode;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [fnlg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fnlg_pkg::CFG_DAT_W-1:0] cfg_data;

    fnlg_restart_if req_if ();
    fnlg_sample_if  smp_if ();

    filtered_noise_loop_generator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (smp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predicted copy of the registers and of the generator state.
    logic [fnlg_pkg::SEED_W-1:0]       gen_seed;
    logic [fnlg_pkg::ALPHA_W-1:0]      gen_alpha;
    logic [fnlg_pkg::LOOPLEN_W-1:0]    gen_loop_len;
    logic [fnlg_pkg::SEED_W-1:0]       gen_noise;
    logic signed [fnlg_pkg::ACC_W-1:0] gen_acc;
    logic [fnlg_pkg::INDEX_W-1:0]      gen_index;
    fnlg_pkg::t_sample                 gen_head [fnlg_pkg::XFADE_SAMPLES];

    bit      pending_restarts [$];
    t_result expected_samples [$];
    int      mismatches;

    // Driver and receiver bookkeeping.
    bit       in_taken;
    bit       just_taken;
    bit       send;
    int       burst_left;
    int       gap_left;
    bit       hold_request;
    int       hold_left;
    int       stretch_left;
    int       rx_cycle;
    t_rx_mode rx_mode;
    logic     rx_ready;

    t_result fresh_result;
    t_result oldest_result;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Start of a loop: reseed, clear the filter and go back to the first sample.
    function automatic void start_loop();
        gen_noise = gen_seed;
        gen_acc   = '0;
        gen_index = '0;
    endfunction

    // Work out the sample that one item produces and advance the state.
    task automatic predict_sample(input logic restart, output t_result res);
        logic [fnlg_pkg::LOOPLEN_W-1:0] len;
        logic [fnlg_pkg::LOOPLEN_W-1:0] pos;
        logic [fnlg_pkg::SEED_W-1:0]    r;
        int                             v;
        int                             x;
        int                             y;
        int                             j;
        int                             mixed;
        longint                         acc_next;
        len = gen_loop_len;
        if (len < fnlg_pkg::MIN_LOOP) begin
            len = fnlg_pkg::MIN_LOOP;
        end
        if (len > fnlg_pkg::MAX_LOOP) begin
            len = fnlg_pkg::MAX_LOOP;
        end
        if (restart) begin
            start_loop();
        end
        pos = fnlg_pkg::LOOPLEN_W'(gen_index);
        if (pos > len - 1) begin
            pos = len - 1;
        end

        // Noise step, centring and one step toward zero.
        r = gen_noise;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        gen_noise = r;
        v = int'(r[15:0]) - 32768;
        if (v > 0) begin
            x = v - 1;
        end else if (v < 0) begin
            x = v + 1;
        end else begin
            x = 0;
        end

        // One-pole low-pass filter in 16.16 fixed point.
        acc_next = longint'(gen_alpha) * longint'(x)
                 + ((longint'(65536) - longint'(gen_alpha)) * longint'(gen_acc)) / 65536;
        gen_acc = acc_next[fnlg_pkg::ACC_W-1:0];
        y = int'(acc_next / 65536);

        // Keep the head of the loop and cross-fade the tail toward it.
        mixed = y;
        if (pos < fnlg_pkg::XFADE_SAMPLES) begin
            gen_head[pos[fnlg_pkg::FADE_W-1:0]] = fnlg_pkg::t_sample'(y);
        end
        if (pos >= len - fnlg_pkg::XFADE_SAMPLES) begin
            j = int'(pos - (len - fnlg_pkg::XFADE_SAMPLES));
            if (j < fnlg_pkg::XFADE_SAMPLES) begin
                mixed = int'((longint'(y) * longint'(fnlg_pkg::XFADE_SAMPLES - j)
                            + longint'(gen_head[j]) * longint'(j))
                            / fnlg_pkg::XFADE_SAMPLES);
            end
        end
        res.sample = fnlg_pkg::t_sample'(mixed);

        if (pos == len - 1) begin
            res.loop_end = 1'b1;
            start_loop();
        end else begin
            res.loop_end = 1'b0;
            gen_index = fnlg_pkg::INDEX_W'(pos + 1);
        end
    endtask

    // Write one register and mirror it in the predicted copy.
    task automatic write_reg(input logic [fnlg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fnlg_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            fnlg_pkg::CFG_SEED: begin
                gen_seed = data;
            end
            fnlg_pkg::CFG_ALPHA: begin
                gen_alpha = data[fnlg_pkg::ALPHA_W-1:0];
            end
            fnlg_pkg::CFG_LOOPLEN: begin
                gen_loop_len = data[fnlg_pkg::LOOPLEN_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Queue items; restart_odds of zero means no restarts, otherwise one in restart_odds.
    task automatic queue_items(input int count, input int restart_odds);
        for (int i = 0; i < count; i++) begin
            pending_restarts.push_back(restart_odds > 0 &&
                                       $urandom_range(restart_odds - 1, 0) == 0);
        end
    endtask

    // Wait until every item has been taken and every sample has come back.
    task automatic wait_idle();
        while (pending_restarts.size() != 0 || expected_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, what, exp_val, act_val);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        just_taken = in_taken;
        if (in_taken) begin
            in_taken = 1'b0;
            pending_restarts.delete(0);
            if (burst_left > 0) begin
                burst_left--;
            end
        end
        if (!req_if.valid || just_taken) begin
            if (burst_left == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            send = (burst_left > 0) && (pending_restarts.size() > 0);
        end else begin
            send = 1'b1;
        end
        req_if.valid   <= send;
        req_if.restart <= send ? pending_restarts[0] : 1'b0;
    end

    // Sample receiver: stretches of differing stall patterns, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (stretch_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            rx_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    rx_ready = 1'b1;
                end
                RX_RANDOM: begin
                    rx_ready = $urandom_range(0, 1);
                end
                RX_EVERY_THIRD: begin
                    rx_ready = (rx_cycle % 3 == 0);
                end
                default: begin
                    rx_ready = ($urandom_range(0, 4) != 0);
                end
            endcase
        end
        smp_if.ready <= rx_ready;
    end

    // Monitor: check each returned sample, then predict for each item taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready) begin
                if (expected_samples.size() == 0) begin
                    note_mismatch("unexpected sample", 0, int'(smp_if.sample));
                end else begin
                    oldest_result = expected_samples.pop_front();
                    if (smp_if.sample !== oldest_result.sample) begin
                        note_mismatch("sample", int'(oldest_result.sample),
                                      int'(smp_if.sample));
                    end
                    if (smp_if.loop_end !== oldest_result.loop_end) begin
                        note_mismatch("loop_end", int'(oldest_result.loop_end),
                                      int'(smp_if.loop_end));
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                predict_sample(req_if.restart, fresh_result);
                expected_samples.push_back(fresh_result);
                in_taken = 1'b1;
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #(25_000_000);
        $display("Verification failed");
        $finish;
    end

    // Test sequence.
    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = fnlg_pkg::CFG_SEED;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        smp_if.ready   = 1'b0;
        mismatches     = 0;
        gen_seed       = fnlg_pkg::SEED_RST;
        gen_alpha      = fnlg_pkg::ALPHA_RST;
        gen_loop_len   = fnlg_pkg::LOOPLEN_RST;
        start_loop();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, with single and back-to-back restarts.
        for (int i = 0; i < 14; i++) begin
            pending_restarts.push_back(DIRECTED_RESTARTS[i]);
        end
        wait_idle();

        // Shortest loop, fastest filter, smallest non-zero seed, starting behind a
        // long receiver hold-off.
        write_reg(fnlg_pkg::CFG_SEED, 32'd1);
        write_reg(fnlg_pkg::CFG_ALPHA, 32'd65535);
        write_reg(fnlg_pkg::CFG_LOOPLEN, 32'd0);
        @(posedge i_clk);
        hold_request = 1'b1;
        queue_items(450, 0);
        wait_idle();

        // All-ones seed, slowest filter, oversized loop length and the spare index.
        write_reg(fnlg_pkg::CFG_SEED, '1);
        write_reg(fnlg_pkg::CFG_ALPHA, 32'd1);
        write_reg(fnlg_pkg::CFG_LOOPLEN, '1);
        write_reg(CFG_SPARE, $urandom);
        queue_items(200, 20);
        wait_idle();

        // Zero alpha holds the accumulator; a zero seed keeps the generator at zero.
        write_reg(fnlg_pkg::CFG_ALPHA, 32'd0);
        queue_items(10, 0);
        wait_idle();
        write_reg(fnlg_pkg::CFG_SEED, 32'd0);
        pending_restarts.push_back(1'b1);
        queue_items(20, 10);
        wait_idle();

        // Exact maximum loop length.
        write_reg(fnlg_pkg::CFG_LOOPLEN, 32'(fnlg_pkg::MAX_LOOP));
        write_reg(fnlg_pkg::CFG_ALPHA, 32'(fnlg_pkg::ALPHA_RST));
        queue_items(20, 5);
        wait_idle();

        // A fresh random seed and alpha, then a change of loop length mid-run.
        write_reg(fnlg_pkg::CFG_SEED, $urandom_range(1, 32'hFFFF_FFFF));
        write_reg(fnlg_pkg::CFG_ALPHA, $urandom_range(1, 65535));
        write_reg(fnlg_pkg::CFG_LOOPLEN, 32'd4500);
        pending_restarts.push_back(1'b1);
        queue_items(199, 0);
        wait_idle();
        write_reg(fnlg_pkg::CFG_LOOPLEN, 32'd4097);
        queue_items(100, 0);
        wait_idle();

        // Random settings with longer runs and occasional restarts.
        for (int k = 0; k < 4; k++) begin
            write_reg(fnlg_pkg::CFG_SEED, $urandom);
            case ($urandom_range(0, 3))
                0: write_reg(fnlg_pkg::CFG_ALPHA, {16'($urandom_range(0, 65535)), 16'd1});
                1: write_reg(fnlg_pkg::CFG_ALPHA, 32'd65535);
                default: write_reg(fnlg_pkg::CFG_ALPHA, {16'($urandom_range(0, 65535)),
                                                         16'($urandom_range(1, 65535))});
            endcase
            if ($urandom_range(0, 4) == 0) begin
                write_reg(fnlg_pkg::CFG_LOOPLEN, $urandom);
            end else begin
                write_reg(fnlg_pkg::CFG_LOOPLEN, $urandom_range(4096, 4600));
            end
            if (k == 2) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            queue_items(150, 40);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/fnlg_pkg.sv
hdl/fnlg_restart_if.sv
hdl/fnlg_sample_if.sv
hdl/filtered_noise_loop_generator_top.sv
sim/tb_filtered_noise_loop_generator_top.sv
